>>> sv/lzfd_pkg.sv
package lzfd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
  } out_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LIT,
    OP_COPY
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  data;
    logic [8:0]  len;
    logic [13:0] off;
    logic        done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LIT,
    PH_KIND,
    PH_SBITS,
    PH_SOFF,
    PH_LB0,
    PH_LB1,
    PH_LEXT
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_PUT,
    BK_FLUSH
  } bk_state_e;

  localparam logic [13:0] LONG_BASE   = 14'h2000;
  localparam logic [13:0] SHORT_BASE  = 14'h0100;
  localparam logic [8:0]  EXT_ADD     = 9'h00A;
  localparam logic [3:0]  FLAG_RELOAD = 4'd9;

endpackage

>>> sv/lzfd_front.sv
module lzfd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lzfd_pkg::in_t         in_data_i,
  input  lzfd_pkg::q_stat_t     q_stat_i,
  output logic                  push_o,
  output lzfd_pkg::cmd_t        cmd_o
);

  lzfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  fs_q, fs_d;
  logic [3:0]  bl_q, bl_d;
  logic [2:0]  cl_q, cl_d;
  logic [7:0]  hold_q, hold_d;
  logic [13:0] off_q, off_d;
  logic        fin_q, fin_d;
  logic        bitwork, accept, bit_now;
  logic [7:0]  b;
  logic [12:0] long_dist;
  logic [2:0]  cl_next;

  assign bitwork = !fin_q && (bl_q > 4'd1) &&
                   (phase_q == lzfd_pkg::PH_FLAG || phase_q == lzfd_pkg::PH_KIND ||
                    phase_q == lzfd_pkg::PH_SBITS);
  assign in_stall_o = bitwork || q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept;
  assign b          = in_data_i.in_byte;
  assign bit_now    = fs_q[0];
  assign long_dist  = 13'({b, 5'b0}) + 13'(hold_q[7:3]);
  assign cl_next    = {cl_q[1:0], bit_now};

  always_comb begin
    phase_d = phase_q;
    fs_d    = fs_q;
    bl_d    = bl_q;
    cl_d    = cl_q;
    hold_d  = hold_q;
    off_d   = off_q;
    fin_d   = fin_q;
    cmd_o.op   = lzfd_pkg::OP_NONE;
    cmd_o.data = b;
    cmd_o.len  = '0;
    cmd_o.off  = off_q;
    cmd_o.done = fin_q;
    if (bitwork) begin
      // one flag bit per cycle, lsb first
      bl_d = bl_q - 4'd1;
      fs_d = {1'b0, fs_q[7:1]};
      unique case (phase_q)
        lzfd_pkg::PH_FLAG: phase_d = bit_now ? lzfd_pkg::PH_LIT : lzfd_pkg::PH_KIND;
        lzfd_pkg::PH_KIND: begin
          if (bit_now) begin
            phase_d = lzfd_pkg::PH_LB0;
          end else begin
            cl_d    = 3'd1;
            phase_d = lzfd_pkg::PH_SBITS;
          end
        end
        default: begin
          cl_d = cl_next;
          if (cl_next[2]) phase_d = lzfd_pkg::PH_SOFF;
        end
      endcase
    end else if (accept && !fin_q) begin
      unique case (phase_q)
        lzfd_pkg::PH_LIT: begin
          cmd_o.op = lzfd_pkg::OP_LIT;
          phase_d  = lzfd_pkg::PH_FLAG;
        end
        lzfd_pkg::PH_SOFF: begin
          cmd_o.op  = lzfd_pkg::OP_COPY;
          cmd_o.len = 9'(cl_q) - 9'd2;
          cmd_o.off = lzfd_pkg::SHORT_BASE - 14'(b);
          phase_d   = lzfd_pkg::PH_FLAG;
        end
        lzfd_pkg::PH_LB0: begin
          hold_d  = b;
          phase_d = lzfd_pkg::PH_LB1;
        end
        lzfd_pkg::PH_LB1: begin
          if ((hold_q | b) == 8'd0) begin
            fin_d   = 1'b1;
            phase_d = lzfd_pkg::PH_FLAG;
          end else begin
            off_d = lzfd_pkg::LONG_BASE - {1'b0, long_dist};
            cmd_o.off = lzfd_pkg::LONG_BASE - {1'b0, long_dist};
            if (hold_q[2:0] != 3'd0) begin
              cmd_o.op  = lzfd_pkg::OP_COPY;
              cmd_o.len = 9'(hold_q[2:0]) + 9'd2;
              phase_d   = lzfd_pkg::PH_FLAG;
            end else begin
              phase_d = lzfd_pkg::PH_LEXT;
            end
          end
        end
        lzfd_pkg::PH_LEXT: begin
          cmd_o.op  = lzfd_pkg::OP_COPY;
          cmd_o.len = 9'(b) + lzfd_pkg::EXT_ADD;
          phase_d   = lzfd_pkg::PH_FLAG;
        end
        default: begin
          fs_d = b;
          bl_d = lzfd_pkg::FLAG_RELOAD;
        end
      endcase
      if (in_data_i.final_byte) fin_d = 1'b1;
      cmd_o.done = fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lzfd_pkg::PH_FLAG;
      fs_q    <= '0;
      bl_q    <= 4'd1;
      cl_q    <= '0;
      hold_q  <= '0;
      off_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fs_q    <= fs_d;
      bl_q    <= bl_d;
      cl_q    <= cl_d;
      hold_q  <= hold_d;
      off_q   <= off_d;
      fin_q   <= fin_d;
    end
  end

endmodule

>>> sv/lzfd_cmd_queue.sv
module lzfd_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lzfd_pkg::cmd_t    data_i,
  input  logic              pop_i,
  output lzfd_pkg::cmd_t    data_o,
  output lzfd_pkg::q_stat_t stat_o
);

  lzfd_pkg::cmd_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign data_o       = slot_q[rp_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> sv/lzfd_back.sv
module lzfd_back #(
  parameter int WINDOW_DEPTH = 8192,
  parameter int OUT_LANES    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lzfd_pkg::cmd_t    cmd_i,
  input  lzfd_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lzfd_pkg::out_t    out_data_o
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [7:0] hist [WINDOW_DEPTH];

  lzfd_pkg::bk_state_e st_q, st_d;
  logic [7:0]    lit_q, lit_d;
  logic          cp_q, cp_d;
  logic [8:0]    rem_q, rem_d;
  logic [AW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic          wrap_q, wrap_d;
  logic          rv_q, rv_d;
  logic [7:0]    rd_q;
  logic [63:0]   acc_q, acc_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          done_q, done_d;
  lzfd_pkg::out_t out_q, out_d;
  logic          ov_q, ov_d;
  logic          out_free, re, we, full;
  logic [7:0]    pb;

  assign out_free    = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign full        = cnt_q == 4'(OUT_LANES);
  // unwritten history reads as zero
  assign pb          = cp_q ? (rv_q ? rd_q : 8'd0) : lit_q;

  always_comb begin
    st_d   = st_q;
    lit_d  = lit_q;
    cp_d   = cp_q;
    rem_d  = rem_q;
    rp_d   = rp_q;
    wp_d   = wp_q;
    wrap_d = wrap_q;
    rv_d   = rv_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    out_d  = out_q;
    ov_d   = ov_q && out_stall_i;
    pop_o  = 1'b0;
    re     = 1'b0;
    we     = 1'b0;
    unique case (st_q)
      lzfd_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          done_d = cmd_i.done;
          unique case (cmd_i.op)
            lzfd_pkg::OP_LIT: begin
              lit_d = cmd_i.data;
              cp_d  = 1'b0;
              st_d  = lzfd_pkg::BK_PUT;
            end
            lzfd_pkg::OP_COPY: begin
              cp_d  = 1'b1;
              rem_d = cmd_i.len;
              rp_d  = wp_q - AW'(cmd_i.off);
              st_d  = lzfd_pkg::BK_READ;
            end
            default: st_d = lzfd_pkg::BK_FLUSH;
          endcase
        end
      end
      lzfd_pkg::BK_READ: begin
        re    = 1'b1;
        rv_d  = wrap_q || (rp_q < wp_q);
        rp_d  = rp_q + AW'(1);
        rem_d = rem_q - 9'd1;
        st_d  = lzfd_pkg::BK_PUT;
      end
      lzfd_pkg::BK_PUT: begin
        if (!full || out_free) begin
          if (full) begin
            ov_d              = 1'b1;
            out_d.out_bytes   = acc_q;
            out_d.byte_count  = cnt_q;
            out_d.run_last    = 1'b0;
            out_d.stream_done = done_q;
            acc_d             = 64'(pb);
            cnt_d             = 4'd1;
          end else begin
            acc_d[8*cnt_q[2:0] +: 8] = pb;
            cnt_d = cnt_q + 4'd1;
          end
          we   = 1'b1;
          wp_d = wp_q + AW'(1);
          if (wp_q == '1) wrap_d = 1'b1;
          st_d = (cp_q && rem_q != 9'd0) ? lzfd_pkg::BK_READ : lzfd_pkg::BK_FLUSH;
        end
      end
      default: begin
        if (out_free) begin
          ov_d              = 1'b1;
          out_d.out_bytes   = acc_q;
          out_d.byte_count  = cnt_q;
          out_d.run_last    = 1'b1;
          out_d.stream_done = done_q;
          acc_d             = '0;
          cnt_d             = '0;
          st_d              = lzfd_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) hist[wp_q] <= pb;
    if (re) rd_q <= hist[rp_q];
  end

  always_ff @(posedge clk_i) begin
    lit_q <= lit_d;
    rp_q  <= rp_d;
    rv_q  <= rv_d;
    rem_q <= rem_d;
    cp_q  <= cp_d;
    out_q <= out_d;
    done_q <= done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= lzfd_pkg::BK_IDLE;
      wp_q   <= '0;
      wrap_q <= 1'b0;
      acc_q  <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      wp_q   <= wp_d;
      wrap_q <= wrap_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

endmodule

>>> sv/lz77_flag_bit_decompressor.sv
// lz77 decompressor with interleaved flag bits: one compressed byte per input word,
// decoded bytes packed up to OUT_LANES per output word, first byte in the low bits.
// every input word yields one or more output words; the last carries run_last, and
// stream_done is set on all words of a step that ends the stream (end marker or
// final_byte). after that the block stays finished until reset. the front decoder
// takes a byte and then consumes the flag bits it holds at one per cycle (up to 8
// after a flag byte), stalling the input meanwhile. the back end pops a command,
// then handles each literal byte with a write and each copied byte with a history
// read, then a write, since every copied byte goes through the single 8192 x 8
// history ram, and then sends the last word of the step. a long copy thus holds
// input back once the two-entry command queue is full. history slots never written
// read as zero, tracked by the write pointer and a wrap flag, so no clearing pass
// is needed.
module lz77_flag_bit_decompressor #(
  parameter int WINDOW_DEPTH = 8192,
  parameter int OUT_LANES    = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lzfd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lzfd_pkg::out_t out_data_o
);

  // decoded command path: front -> queue -> back
  lzfd_pkg::cmd_t    push_cmd, pop_cmd;
  lzfd_pkg::q_stat_t q_stat;
  logic              push, pop;

  lzfd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  lzfd_cmd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (pop_cmd),
    .stat_o (q_stat)
  );

  lzfd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .OUT_LANES    (OUT_LANES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_i       (pop_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

`ifndef NO_ASSERTIONS
  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("command queue overflow");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("command queue underflow");

  // packing never exceeds the lane count
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.byte_count <= 4'(OUT_LANES))
    else $error("byte_count above lane count");

  // a word that is not the last of its step is always full
  a_mid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run_last) |-> out_data_o.byte_count == 4'(OUT_LANES))
    else $error("partial word before end of step");
`endif

endmodule
